// File: rtl/slprc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slprc_pkg
// Shared types and constants for the sensor link retry controller.
// ----------------------------------------------------------------------------
package slprc_pkg;

  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_PAIR   = 3'd1;
  localparam logic [2:0] CMD_ACK    = 3'd2;
  localparam logic [2:0] CMD_NAK    = 3'd3;
  localparam logic [2:0] CMD_REPAIR = 3'd4;

  localparam logic [1:0] MSG_NONE  = 2'd0;
  localparam logic [1:0] MSG_PAIR  = 2'd1;
  localparam logic [1:0] MSG_DATA  = 2'd2;
  localparam logic [1:0] MSG_HBEAT = 2'd3;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_WAIT  = 2'd1;
  localparam logic [1:0] PH_DELAY = 2'd2;
  localparam logic [1:0] PH_RWAIT = 2'd3;

  localparam logic [2:0] REG_UPDATE = 3'd0;
  localparam logic [2:0] REG_ACKTO  = 3'd1;
  localparam logic [2:0] REG_MAXRET = 3'd2;
  localparam logic [2:0] REG_PAIRIV = 3'd3;
  localparam logic [2:0] REG_MAXPA  = 3'd4;
  localparam logic [2:0] REG_HBEAT  = 3'd5;
  localparam logic [2:0] REG_HOLD   = 3'd6;
  localparam logic [2:0] REG_START  = 3'd7;

  localparam logic [31:0] COOLDOWN_MS  = 32'd60000;
  localparam logic [31:0] RETRY_GAP_MS = 32'd50;

  typedef struct packed {
    logic [2:0]  command;
    logic        pir_level;
    logic        pair_accepted;
    logic        ack_denied;
    logic        gateway_lost;
    logic [15:0] slot_in;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind0;
    logic [15:0] seq0;
    logic [1:0]  kind1;
    logic [15:0] seq1;
    logic        two;
    logic        motion;
    logic        paired;
    logic        connected;
    logic [15:0] slot;
    logic [1:0]  phase;
  } res_t;

endpackage

// File: rtl/slprc_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slprc_fifo
// Two-entry item queue between the front and back parts.
// ----------------------------------------------------------------------------
module slprc_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  slprc_pkg::cmd_t   in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output slprc_pkg::cmd_t   out_data
);
  import slprc_pkg::*;

  cmd_t       mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mem[wptr] <= in_data;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (in_valid && in_ready) wptr <= ~wptr;
      if (out_valid && out_ready) rptr <= ~rptr;
      count <= count + {1'b0, in_valid && in_ready} - {1'b0, out_valid && out_ready};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !in_ready) else $error("queue overflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("bad queue count");
  a_empty_hold: assert property (@(posedge clk) disable iff (rst)
    count == 2'd0 && !in_valid |=> !out_valid) else $error("empty queue gave an item");

endmodule

// File: rtl/slprc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slprc_core
// Back part: link state update, one item per cycle unless the result is held, registered result.
// ----------------------------------------------------------------------------
module slprc_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_idx,
  input  logic [23:0]      cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  slprc_pkg::cmd_t  in_data,
  output logic             res_valid,
  input  logic             res_ready,
  output slprc_pkg::res_t  res_data
);
  import slprc_pkg::*;

  logic [23:0] update_iv, pair_iv, hbeat_iv, hold_t;
  logic [15:0] ack_to;
  logic [3:0]  max_ret, max_pa;
  logic        started;

  logic [31:0] now_ms, last_motion, last_send, last_pair, cool_end, last_hb;
  logic [31:0] ack_dl, retry_dl;
  logic        motion_held, is_paired, is_conn, ack_seen;
  logic [3:0]  pair_tries, retries;
  logic [1:0]  phase;
  logic [15:0] next_seq, slot;

  logic [31:0] now_ms_next, last_motion_next, last_send_next, last_pair_next;
  logic [31:0] cool_end_next, last_hb_next, ack_dl_next, retry_dl_next;
  logic        motion_held_next, is_paired_next, is_conn_next, ack_seen_next;
  logic [3:0]  pair_tries_next, retries_next;
  logic [1:0]  phase_next;
  logic [15:0] next_seq_next, slot_next;
  res_t        res_next;
  logic [1:0]  nmsg;
  logic        fire;

  assign in_ready = !res_valid || res_ready;
  assign fire     = in_valid && in_ready;

  always_comb begin
    now_ms_next = now_ms; last_motion_next = last_motion; last_send_next = last_send;
    last_pair_next = last_pair; cool_end_next = cool_end; last_hb_next = last_hb;
    ack_dl_next = ack_dl; retry_dl_next = retry_dl; motion_held_next = motion_held;
    is_paired_next = is_paired; is_conn_next = is_conn; ack_seen_next = ack_seen;
    pair_tries_next = pair_tries; retries_next = retries; phase_next = phase;
    next_seq_next = next_seq; slot_next = slot;
    res_next = '0;
    nmsg = 2'd0;
    case (in_data.command)
      CMD_TICK: begin
        now_ms_next = now_ms + 32'd1;
        if (in_data.pir_level) begin
          last_motion_next = now_ms_next;
          if (!motion_held) begin
            motion_held_next = 1'b1;
            last_send_next   = '0;
          end
        end else if (motion_held && (now_ms_next - last_motion) >= {8'd0, hold_t}) begin
          motion_held_next = 1'b0;
          last_send_next   = '0;
        end
        if (!is_paired) begin
          if (now_ms_next >= cool_end &&
              (now_ms_next - last_pair) > {8'd0, pair_iv}) begin
            last_pair_next  = now_ms_next;
            pair_tries_next = pair_tries + 4'd1;
            res_next.kind0  = MSG_PAIR;
            res_next.seq0   = next_seq;
            next_seq_next   = next_seq + 16'd1;
            ack_seen_next   = 1'b0;
            nmsg            = 2'd1;
            if (pair_tries_next >= max_pa) begin
              pair_tries_next = '0;
              cool_end_next   = now_ms_next + COOLDOWN_MS;
            end
          end
        end else begin
          unique case (phase)
            PH_IDLE: begin
              if ((now_ms_next - last_send_next) > {8'd0, update_iv}) begin
                last_send_next = now_ms_next;
                res_next.kind0 = MSG_DATA;
                res_next.seq0  = next_seq;
                next_seq_next  = next_seq + 16'd1;
                ack_seen_next  = 1'b0;
                nmsg           = 2'd1;
                phase_next     = PH_WAIT;
                ack_dl_next    = now_ms_next + {16'd0, ack_to};
              end
            end
            PH_WAIT, PH_RWAIT: begin
              if (ack_seen) begin
                is_conn_next = 1'b1;
                phase_next   = PH_IDLE;
                retries_next = '0;
              end else if (now_ms_next >= ack_dl) begin
                if (phase == PH_WAIT) is_conn_next = 1'b0;
                if (retries < max_ret) begin
                  retries_next  = retries + 4'd1;
                  phase_next    = PH_DELAY;
                  retry_dl_next = now_ms_next + RETRY_GAP_MS;
                end else begin
                  is_paired_next  = 1'b0;
                  pair_tries_next = '0;
                  last_pair_next  = '0;
                  phase_next      = PH_IDLE;
                  retries_next    = '0;
                end
              end
            end
            default: begin
              if (now_ms_next >= retry_dl) begin
                res_next.kind0 = MSG_DATA;
                res_next.seq0  = next_seq;
                next_seq_next  = next_seq + 16'd1;
                ack_seen_next  = 1'b0;
                nmsg           = 2'd1;
                phase_next     = PH_RWAIT;
                ack_dl_next    = now_ms_next + {16'd0, ack_to};
              end
            end
          endcase
          if ((now_ms_next - last_hb) > {8'd0, hbeat_iv}) begin
            last_hb_next = now_ms_next;
            if (is_paired_next) begin
              // heartbeat takes the first free result slot
              if (nmsg == 2'd0) begin
                res_next.kind0 = MSG_HBEAT;
                res_next.seq0  = next_seq_next;
              end else begin
                res_next.kind1 = MSG_HBEAT;
                res_next.seq1  = next_seq_next;
                res_next.two   = 1'b1;
              end
              next_seq_next = next_seq_next + 16'd1;
              ack_seen_next = 1'b0;
            end
          end
        end
      end
      CMD_PAIR: begin
        if (in_data.pair_accepted) begin
          slot_next = in_data.slot_in;
          is_paired_next = 1'b1;
          is_conn_next = 1'b1;
        end
      end
      CMD_ACK: begin
        is_paired_next = is_paired && !in_data.ack_denied;
        is_conn_next   = !in_data.ack_denied;
        ack_seen_next  = 1'b1;
      end
      CMD_NAK: begin
        if (in_data.gateway_lost) begin
          is_paired_next = 1'b0;
          is_conn_next = 1'b0;
          pair_tries_next = '0;
        end
      end
      CMD_REPAIR: begin
        is_paired_next = 1'b0;
        is_conn_next = 1'b0;
        pair_tries_next = '0;
        res_next.kind0 = MSG_PAIR;
        res_next.seq0 = next_seq;
        next_seq_next = next_seq + 16'd1;
        ack_seen_next = 1'b0;
      end
      default: ;
    endcase
    res_next.motion    = motion_held_next;
    res_next.paired    = is_paired_next;
    res_next.connected = is_conn_next;
    res_next.slot      = slot_next;
    res_next.phase     = phase_next;
  end

  always_ff @(posedge clk) begin
    if (fire) res_data <= res_next;
    if (rst) begin
      update_iv <= 24'd5000; ack_to <= 16'd500; max_ret <= 4'd3;
      pair_iv <= 24'd5000; max_pa <= 4'd5; hbeat_iv <= 24'd30000;
      hold_t <= 24'd30000; started <= 1'b0;
      now_ms <= '0; last_motion <= '0; last_send <= '0; last_pair <= '0;
      cool_end <= '0; last_hb <= '0; ack_dl <= '0; retry_dl <= '0;
      motion_held <= 1'b0; is_paired <= 1'b0; is_conn <= 1'b0; ack_seen <= 1'b0;
      pair_tries <= '0; retries <= '0; phase <= PH_IDLE;
      next_seq <= '0; slot <= '0; res_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_UPDATE: update_iv <= cfg_data;
          REG_ACKTO:  ack_to    <= cfg_data[15:0];
          REG_MAXRET: max_ret   <= cfg_data[3:0];
          REG_PAIRIV: pair_iv   <= cfg_data;
          REG_MAXPA:  max_pa    <= cfg_data[3:0];
          REG_HBEAT:  hbeat_iv  <= cfg_data;
          REG_HOLD:   hold_t    <= cfg_data;
          default: begin
            // stored gateway flag only matters before the first item
            if (!started) is_paired <= cfg_data[0];
          end
        endcase
      end
      if (fire) begin
        started <= 1'b1;
        now_ms <= now_ms_next; last_motion <= last_motion_next;
        last_send <= last_send_next; last_pair <= last_pair_next;
        cool_end <= cool_end_next; last_hb <= last_hb_next;
        ack_dl <= ack_dl_next; retry_dl <= retry_dl_next;
        motion_held <= motion_held_next; is_paired <= is_paired_next;
        is_conn <= is_conn_next; ack_seen <= ack_seen_next;
        pair_tries <= pair_tries_next; retries <= retries_next;
        phase <= phase_next; next_seq <= next_seq_next; slot <= slot_next;
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  a_time_step: assert property (@(posedge clk) disable iff (rst)
    fire && in_data.command == CMD_TICK |=> now_ms == $past(now_ms) + 32'd1)
    else $error("tick did not advance time");
  a_time_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(now_ms)) else $error("time moved without an item");
  a_unpaired_phase: assert property (@(posedge clk) disable iff (rst)
    fire && !is_paired && in_data.command == CMD_TICK |=> $stable(phase))
    else $error("send phase moved while unpaired");

endmodule

// File: rtl/slprc_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slprc_out
// Result sequencer: splits a result record into one or two output items.
// ----------------------------------------------------------------------------
module slprc_out (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  slprc_pkg::res_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       message_kind,
  output logic [15:0]      sequence_res,
  output logic             motion,
  output logic             paired,
  output logic             connected,
  output logic [15:0]      slot,
  output logic [1:0]       send_phase,
  output logic             last
);
  import slprc_pkg::*;

  logic second;

  assign out_valid    = in_valid;
  assign message_kind = second ? in_data.kind1 : in_data.kind0;
  assign sequence_res = second ? in_data.seq1 : in_data.seq0;
  assign motion       = in_data.motion;
  assign paired       = in_data.paired;
  assign connected    = in_data.connected;
  assign slot         = in_data.slot;
  assign send_phase   = in_data.phase;
  assign last         = second || !in_data.two;
  // release the record only after its final item
  assign in_ready     = out_ready && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
    end else if (in_valid && out_ready) begin
      second <= !last;
    end
  end

  a_second_two: assert property (@(posedge clk) disable iff (rst)
    second |-> in_valid && in_data.two) else $error("second item without record");
  a_second_done: assert property (@(posedge clk) disable iff (rst)
    second && out_ready |=> !second) else $error("second item repeated");
  a_first_then: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_data.two && !second && out_ready |=> second)
    else $error("second item lost");

endmodule

// File: rtl/sensor_link_pair_retry_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_link_pair_retry_controller_unit
// Motion sensor link controller: pairing, data sends with retry, heartbeat.
// ----------------------------------------------------------------------------
// An accepted item enters a two-entry queue, is applied to the link state by
// the core and leaves as one output item, or two when a data send and a
// heartbeat fall on the same tick. One item per cycle is taken while the
// output is ready and each gives a single output item; a two-item result
// holds the output stage until both are taken. Configuration writes take
// effect at once and must be made while idle; the block does not enforce it.
module sensor_link_pair_retry_controller_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  command,
  input  logic        pir_level,
  input  logic        pair_accepted,
  input  logic        ack_denied,
  input  logic        gateway_lost,
  input  logic [15:0] slot_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  message_kind,
  output logic [15:0] sequence_res,
  output logic        motion,
  output logic        paired,
  output logic        connected,
  output logic [15:0] slot,
  output logic [1:0]  send_phase,
  output logic        last
);
  import slprc_pkg::*;

  cmd_t in_item, q_item;
  res_t res;
  logic q_valid, q_ready, r_valid, r_ready;

  assign in_item = '{command: command, pir_level: pir_level,
                     pair_accepted: pair_accepted, ack_denied: ack_denied,
                     gateway_lost: gateway_lost, slot_in: slot_in};

  slprc_fifo u_fifo (
    .clk, .rst, .in_valid, .in_ready, .in_data(in_item),
    .out_valid(q_valid), .out_ready(q_ready), .out_data(q_item)
  );

  slprc_core u_core (
    .clk, .rst, .cfg_we, .cfg_idx, .cfg_data,
    .in_valid(q_valid), .in_ready(q_ready), .in_data(q_item),
    .res_valid(r_valid), .res_ready(r_ready), .res_data(res)
  );

  slprc_out u_out (
    .clk, .rst, .in_valid(r_valid), .in_ready(r_ready), .in_data(res),
    .out_valid, .out_ready, .message_kind, .sequence_res, .motion, .paired,
    .connected, .slot, .send_phase, .last
  );

endmodule
